>>> src/rvg_pkg.sv
// Shared types, constants and lookup functions for the ring vertex generator.
`timescale 1ns / 1ps

package rvg_pkg;

  localparam int MAX_SEGMENTS = 63;
  localparam int MIN_SEGMENTS = 3;
  localparam int SEG_W        = 6;
  localparam int COORD_W      = 32;
  localparam int AXIS_W       = 16;
  localparam int ANGLE_W      = 16;
  localparam int STEP_W       = 15;
  localparam int TRIG_W       = 16;
  localparam int CFG_INDEX_W  = 2;
  localparam int IN_TDATA_W   = 240;
  localparam int OUT_TDATA_W  = 200;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SEG_COUNT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_CUT = 2'd1;

  localparam logic [SEG_W-1:0] SEG_COUNT_RESET = 6'd16;

  // Quarter wave of sine, Q1.14
  localparam logic [14:0] SINE_QUARTER [0:64] = '{
    15'd0,     15'd402,   15'd804,   15'd1205,  15'd1606,  15'd2006,  15'd2404,  15'd2801,
    15'd3196,  15'd3590,  15'd3981,  15'd4370,  15'd4756,  15'd5139,  15'd5520,  15'd5897,
    15'd6270,  15'd6639,  15'd7005,  15'd7366,  15'd7723,  15'd8076,  15'd8423,  15'd8765,
    15'd9102,  15'd9434,  15'd9760,  15'd10080, 15'd10394, 15'd10702, 15'd11003, 15'd11297,
    15'd11585, 15'd11866, 15'd12140, 15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395,
    15'd13623, 15'd13842, 15'd14053, 15'd14255, 15'd14449, 15'd14634, 15'd14811, 15'd14978,
    15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15678, 15'd15790, 15'd15893, 15'd15986,
    15'd16069, 15'd16143, 15'd16207, 15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379,
    15'd16384
  };

  typedef struct packed {
    logic             load;
    logic             issue;
    logic [SEG_W-1:0] idx;
    logic             last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic en;
    logic busy;
  } dp_status_t;

  function automatic logic signed [TRIG_W-1:0] rom_sin(input logic [7:0] i);
    logic [5:0]  j;
    logic [14:0] mag;
    j   = i[5:0];
    mag = i[6] ? SINE_QUARTER[7'd64 - {1'b0, j}] : SINE_QUARTER[{1'b0, j}];
    return i[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic [SEG_W-1:0] seg_clamp(input logic [SEG_W-1:0] s);
    if (s < SEG_W'(MIN_SEGMENTS))
      return SEG_W'(MIN_SEGMENTS);
    else if (s > SEG_W'(MAX_SEGMENTS))
      return SEG_W'(MAX_SEGMENTS);
    else
      return s;
  endfunction

  // One turn (65536 in Q8.8) over the segment count, truncated
  function automatic logic [STEP_W-1:0] step_for(input logic [SEG_W-1:0] s);
    logic [STEP_W-1:0] r;
    case (s)
      6'd3:  r = 15'd21845;  6'd4:  r = 15'd16384;  6'd5:  r = 15'd13107;
      6'd6:  r = 15'd10922;  6'd7:  r = 15'd9362;   6'd8:  r = 15'd8192;
      6'd9:  r = 15'd7281;   6'd10: r = 15'd6553;   6'd11: r = 15'd5957;
      6'd12: r = 15'd5461;   6'd13: r = 15'd5041;   6'd14: r = 15'd4681;
      6'd15: r = 15'd4369;   6'd16: r = 15'd4096;   6'd17: r = 15'd3855;
      6'd18: r = 15'd3640;   6'd19: r = 15'd3449;   6'd20: r = 15'd3276;
      6'd21: r = 15'd3120;   6'd22: r = 15'd2978;   6'd23: r = 15'd2849;
      6'd24: r = 15'd2730;   6'd25: r = 15'd2621;   6'd26: r = 15'd2520;
      6'd27: r = 15'd2427;   6'd28: r = 15'd2340;   6'd29: r = 15'd2259;
      6'd30: r = 15'd2184;   6'd31: r = 15'd2114;   6'd32: r = 15'd2048;
      6'd33: r = 15'd1985;   6'd34: r = 15'd1927;   6'd35: r = 15'd1872;
      6'd36: r = 15'd1820;   6'd37: r = 15'd1771;   6'd38: r = 15'd1724;
      6'd39: r = 15'd1680;   6'd40: r = 15'd1638;   6'd41: r = 15'd1598;
      6'd42: r = 15'd1560;   6'd43: r = 15'd1524;   6'd44: r = 15'd1489;
      6'd45: r = 15'd1456;   6'd46: r = 15'd1424;   6'd47: r = 15'd1394;
      6'd48: r = 15'd1365;   6'd49: r = 15'd1337;   6'd50: r = 15'd1310;
      6'd51: r = 15'd1285;   6'd52: r = 15'd1260;   6'd53: r = 15'd1236;
      6'd54: r = 15'd1213;   6'd55: r = 15'd1191;   6'd56: r = 15'd1170;
      6'd57: r = 15'd1149;   6'd58: r = 15'd1129;   6'd59: r = 15'd1110;
      6'd60: r = 15'd1092;   6'd61: r = 15'd1074;   6'd62: r = 15'd1057;
      6'd63: r = 15'd1040;
      default: r = 15'd21845;
    endcase
    return r;
  endfunction

endpackage

>>> src/ring_vertex_generator.sv
// Top level of the ring vertex generator: ports, config registers, controller and datapath.
`timescale 1ns / 1ps

// Ring vertex generator. Each input item describes one ring (center, plane
// basis U and V in Q2.14, radius in Q16.16, start angle in Q8.8 256ths of a
// turn); the block emits seg_count+1 result items, one per ring point,
// carrying the outer vertex center + radius*(cos*U + sin*V) and the inner
// vertex with (radius - radius_cut) in place of radius, all Q16.16 with
// rounding to nearest and saturation. A zero radius puts the inner vertex on
// the center. seg_count is clamped to 3..63. Points come out one per cycle,
// while the output is not stalled, through a six-stage pipeline (trig ROM,
// basis products, sum, radius multiply, round, center add). A new ring is
// taken only after every point of the last one has been issued and has
// passed the round stage, since the ring's operands live in one set of item
// registers. Output backpressure stalls the whole pipe. Config writes are
// taken at any time (cfg_ready is tied high) but belong between rings; an
// unknown index is ignored.
module ring_vertex_generator (
  input  logic                          clk,
  input  logic                          rst_n,
  // center_x, center_y, center_z, axis_u_x/y/z, axis_v_x/y/z, radius, start_angle
  input  logic [rvg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // outer_x/y/z, inner_x/y/z, point_index, zero pad
  output logic [rvg_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                          out_tlast,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rvg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rvg_pkg::COORD_W-1:0]   cfg_data
);
  import rvg_pkg::*;

  logic [SEG_W-1:0]          seg_count_r;
  logic signed [COORD_W-1:0] radius_cut_r;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  logic [3*COORD_W-1:0] outer_xyz, inner_xyz;
  logic [SEG_W-1:0]     point_index;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_count_r  <= SEG_COUNT_RESET;
      radius_cut_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SEG_COUNT:  seg_count_r  <= cfg_data[SEG_W-1:0];
        REG_RADIUS_CUT: radius_cut_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rvg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .seg_count (seg_count_r),
    .status    (status),
    .cmd       (cmd)
  );

  rvg_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .item       (in_tdata),
    .seg_count  (seg_count_r),
    .radius_cut (radius_cut_r),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .outer_xyz  (outer_xyz),
    .inner_xyz  (inner_xyz),
    .out_idx    (point_index),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, point_index, inner_xyz, outer_xyz};

  // A new ring is only taken once no earlier point is still in stages A to E
  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !status.busy)
    else $error("ring accepted while points still in flight");

  // After taking a ring the controller stops taking items
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still open after ring accepted");

  // Points never enter a stalled pipeline
  a_issue_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> status.en)
    else $error("point issued while pipeline stalled");

endmodule

>>> src/rvg_ctrl.sv
// Controller: takes ring items and issues one ring point per pipeline advance.
`timescale 1ns / 1ps

module rvg_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rvg_pkg::SEG_W-1:0] seg_count,
  input  rvg_pkg::dp_status_t      status,
  output rvg_pkg::ctrl_cmd_t       cmd
);
  import rvg_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SEG_W-1:0] k_r, k_nxt;
  logic [SEG_W-1:0] seg_r, seg_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign cmd.load  = in_ready && in_valid;
  assign cmd.issue = (state_r == ST_RUN) && status.en;
  assign cmd.idx   = k_r;
  assign cmd.last  = (k_r == seg_r);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    seg_nxt   = seg_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.load) begin
          state_nxt = ST_RUN;
          k_nxt     = '0;
          seg_nxt   = seg_clamp(seg_count);
        end
      end
      ST_RUN: begin
        if (cmd.issue) begin
          if (cmd.last)
            state_nxt = ST_DRAIN;
          else
            k_nxt = k_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status.busy)
          state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= '0;
      seg_r   <= SEG_W'(MIN_SEGMENTS);
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      seg_r   <= seg_nxt;
    end
  end

endmodule

>>> src/rvg_datapath.sv
// Datapath: angle walk, trig lookup, basis mix, radius scale, round and saturate.
`timescale 1ns / 1ps

module rvg_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rvg_pkg::ctrl_cmd_t                  cmd,
  output rvg_pkg::dp_status_t                 status,
  input  logic [rvg_pkg::IN_TDATA_W-1:0]      item,
  input  logic [rvg_pkg::SEG_W-1:0]           seg_count,
  input  logic signed [rvg_pkg::COORD_W-1:0]  radius_cut,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [3*rvg_pkg::COORD_W-1:0]       outer_xyz,
  output logic [3*rvg_pkg::COORD_W-1:0]       inner_xyz,
  output logic [rvg_pkg::SEG_W-1:0]           out_idx,
  output logic                                out_last
);
  import rvg_pkg::*;

  localparam int RND_W = 37;

  function automatic logic [COORD_W-1:0] sat_add(input logic signed [COORD_W-1:0] c,
                                                 input logic signed [RND_W-1:0] d);
    logic signed [RND_W:0] s;
    s = {{(RND_W+1-COORD_W){c[COORD_W-1]}}, c} + {d[RND_W-1], d};
    if (s > (RND_W+1)'($signed(32'h7fffffff)))
      return 32'h7fffffff;
    else if (s < (RND_W+1)'($signed(32'h80000000)))
      return 32'h80000000;
    else
      return s[COORD_W-1:0];
  endfunction

  // Round Q.44 to Q16.16, halves away from zero
  function automatic logic signed [RND_W-1:0] round_q28(input logic signed [64:0] x);
    logic signed [64:0] t;
    t = x + 65'sd134217728 - {64'd0, x[64]};
    return t[64:28];
  endfunction

  logic en;
  assign en = !out_valid || out_ready;

  // Item registers, loaded once per ring
  logic signed [COORD_W-1:0] center_r [3];
  logic signed [AXIS_W-1:0]  u_r [3];
  logic signed [AXIS_W-1:0]  v_r [3];
  logic signed [COORD_W-1:0] radius_r;
  logic signed [COORD_W:0]   r_in_r;
  logic                      rzero_r;
  logic [STEP_W-1:0]         step_r;
  logic [ANGLE_W-1:0]        angle_r;

  // Pipeline stage valids and tags
  logic             va_r, vb_r, vc_r, vd_r, ve_r, vf_r;
  logic [SEG_W-1:0] ia_r, ib_r, ic_r, id_r, ie_r, if_r;
  logic             la_r, lb_r, lc_r, ld_r, le_r, lf_r;

  logic signed [TRIG_W-1:0]    cs_r, sn_r;
  logic signed [2*AXIS_W-1:0]  pu_r [3];
  logic signed [2*AXIS_W-1:0]  pv_r [3];
  logic signed [COORD_W-1:0]   dir_r [3];
  logic signed [2*COORD_W-1:0] mo_r [3];
  logic signed [2*COORD_W:0]   mi_r [3];
  logic signed [RND_W-1:0]     ro_r [3];
  logic signed [RND_W-1:0]     ri_r [3];
  logic [COORD_W-1:0]          oo_r [3];
  logic [COORD_W-1:0]          oi_r [3];

  assign status.en   = en;
  assign status.busy = va_r || vb_r || vc_r || vd_r || ve_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int d = 0; d < 3; d++) begin
        center_r[d] <= item[COORD_W*d +: COORD_W];
        u_r[d]      <= item[96 + AXIS_W*d +: AXIS_W];
        v_r[d]      <= item[144 + AXIS_W*d +: AXIS_W];
      end
      radius_r <= item[223:192];
      r_in_r   <= {item[223], item[223:192]} - {radius_cut[COORD_W-1], radius_cut};
      rzero_r  <= (item[223:192] == '0);
      step_r   <= step_for(seg_clamp(seg_count));
      angle_r  <= item[239:224];
    end else if (cmd.issue) begin
      angle_r <= angle_r + ANGLE_W'(step_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0; vb_r <= 1'b0; vc_r <= 1'b0;
      vd_r <= 1'b0; ve_r <= 1'b0; vf_r <= 1'b0;
    end else if (en) begin
      va_r <= cmd.issue;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // A: trig lookup
      cs_r <= rom_sin(angle_r[15:8] + 8'd64);
      sn_r <= rom_sin(angle_r[15:8]);
      ia_r <= cmd.idx;  la_r <= cmd.last;
      // B: basis products
      for (int d = 0; d < 3; d++) begin
        pu_r[d] <= cs_r * u_r[d];
        pv_r[d] <= sn_r * v_r[d];
      end
      ib_r <= ia_r;  lb_r <= la_r;
      // C: direction, exact in Q.28
      for (int d = 0; d < 3; d++)
        dir_r[d] <= pu_r[d] + pv_r[d];
      ic_r <= ib_r;  lc_r <= lb_r;
      // D: radius scale
      for (int d = 0; d < 3; d++) begin
        mo_r[d] <= radius_r * dir_r[d];
        mi_r[d] <= r_in_r * $signed({dir_r[d][COORD_W-1], dir_r[d]});
      end
      id_r <= ic_r;  ld_r <= lc_r;
      // E: round
      for (int d = 0; d < 3; d++) begin
        ro_r[d] <= round_q28({mo_r[d][2*COORD_W-1], mo_r[d]});
        ri_r[d] <= round_q28(mi_r[d]);
      end
      ie_r <= id_r;  le_r <= ld_r;
      // F: add center, saturate
      for (int d = 0; d < 3; d++) begin
        oo_r[d] <= sat_add(center_r[d], ro_r[d]);
        oi_r[d] <= rzero_r ? center_r[d] : sat_add(center_r[d], ri_r[d]);
      end
      if_r <= ie_r;  lf_r <= le_r;
    end
  end

  assign out_valid = vf_r;
  assign outer_xyz = {oo_r[2], oo_r[1], oo_r[0]};
  assign inner_xyz = {oi_r[2], oi_r[1], oi_r[0]};
  assign out_idx   = if_r;
  assign out_last  = lf_r;

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for ring_vertex_generator: directed table, random rings, checker.
`timescale 1ns / 1ps

module tb_top;
  import rvg_pkg::*;

  localparam int     RINGS_PER_PHASE = 36;
  localparam int     NUM_PHASES      = 12;
  localparam int     SETTLE_CYCLES   = 12;    // pipeline is six stages deep plus issue
  localparam int     LONG_HOLD       = 400;   // long output stall, lets the pipe back up
  localparam int     IDLE_LIMIT      = 3000;  // cycles with no handshake at all
  localparam int     MAX_PRINTS      = 40;
  localparam int     C_MAX           = 32'sh7FFF_FFFF;
  localparam int     C_MIN           = 32'sh8000_0000;
  localparam longint SAT_HI          = 64'sd2147483647;
  localparam longint SAT_LO          = -64'sd2147483648;

  // Register indexes with no register behind them; writes must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

  // Quarter sine wave, Q1.14, 64 steps per quadrant
  localparam int QUARTER_WAVE [0:64] = '{
    0, 402, 804, 1205, 1606, 2006, 2404, 2801, 3196, 3590,
    3981, 4370, 4756, 5139, 5520, 5897, 6270, 6639, 7005, 7366,
    7723, 8076, 8423, 8765, 9102, 9434, 9760, 10080, 10394, 10702,
    11003, 11297, 11585, 11866, 12140, 12406, 12665, 12916, 13160, 13395,
    13623, 13842, 14053, 14255, 14449, 14634, 14811, 14978, 15137, 15286,
    15426, 15557, 15678, 15790, 15893, 15986, 16069, 16143, 16207, 16261,
    16305, 16340, 16364, 16379, 16384
  };

  // One ring item, laid out exactly as in_tdata (center_x in the lowest bits)
  typedef struct packed {
    logic        [15:0] start_angle;
    logic signed [31:0] radius;
    logic signed [15:0] v_z, v_y, v_x;
    logic signed [15:0] u_z, u_y, u_x;
    logic signed [31:0] c_z, c_y, c_x;
  } ring_t;

  // One ring point, laid out as {out_tlast, out_tdata[197:0]}
  typedef struct packed {
    logic               last;
    logic        [5:0]  index;
    logic signed [31:0] in_z, in_y, in_x;
    logic signed [31:0] out_z, out_y, out_x;
  } point_t;

  typedef enum logic [1:0] {ROW_RING, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_INDEX_W-1:0] cfg_idx;
    logic [31:0]            cfg_val;
    logic                   on_center;  // every point, outer and inner, sits on the center
    ring_t                  ring;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [COORD_W-1:0]     cfg_data;

  ring_vertex_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 0;
  end

  // Shadow of the block's registers
  logic [SEG_W-1:0]   seg_reg = SEG_COUNT_RESET;
  logic signed [31:0] cut_reg = '0;

  point_t points_due [$];
  int     mismatch_count = 0;
  int     points_seen    = 0;
  row_t   plan [$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  function automatic longint trig(input logic [7:0] i);
    longint m;
    m = i[6] ? QUARTER_WAVE[64 - i[5:0]] : QUARTER_WAVE[i[5:0]];
    return i[7] ? -m : m;
  endfunction

  // center + rad*dir, dir in Q.28, rounded half away from zero, saturated
  function automatic logic [31:0] place(input longint c, input longint dir, input longint rad);
    longint prod, mag, sum;
    prod = rad * dir;
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + (longint'(1) <<< 27)) >>> 28;
    sum  = c + ((prod < 0) ? -mag : mag);
    if (sum > SAT_HI) return 32'h7FFF_FFFF;
    if (sum < SAT_LO) return 32'h8000_0000;
    return sum[31:0];
  endfunction

  function automatic point_t ring_point(input ring_t r, input logic [15:0] ang);
    longint c [3], u [3], v [3];
    longint cs, sn, dir, rad, r_in;
    logic [31:0] o [3], n [3];
    point_t p;
    c = '{longint'(r.c_x), longint'(r.c_y), longint'(r.c_z)};
    u = '{longint'(r.u_x), longint'(r.u_y), longint'(r.u_z)};
    v = '{longint'(r.v_x), longint'(r.v_y), longint'(r.v_z)};
    rad  = longint'(r.radius);
    r_in = rad - longint'(cut_reg);
    cs   = trig(ang[15:8] + 8'd64);
    sn   = trig(ang[15:8]);
    for (int d = 0; d < 3; d++) begin
      dir  = cs * u[d] + sn * v[d];
      o[d] = place(c[d], dir, rad);
      // zero radius pins the inner vertex to the center whatever the cut
      n[d] = (rad == 0) ? c[d][31:0] : place(c[d], dir, r_in);
    end
    p       = '0;
    p.out_x = o[0];
    p.out_y = o[1];
    p.out_z = o[2];
    p.in_x  = n[0];
    p.in_y  = n[1];
    p.in_z  = n[2];
    return p;
  endfunction

  // Queue up every point of one accepted ring
  task automatic predict_ring(input ring_t r, input logic on_center);
    int          segs, step;
    logic [15:0] ang;
    point_t      p;
    segs = int'(seg_reg);
    if (segs < MIN_SEGMENTS) segs = MIN_SEGMENTS;
    if (segs > MAX_SEGMENTS) segs = MAX_SEGMENTS;
    step = 65536 / segs;
    ang  = r.start_angle;
    for (int k = 0; k <= segs; k++) begin
      if (on_center) begin
        p       = '0;
        p.out_x = r.c_x;
        p.out_y = r.c_y;
        p.out_z = r.c_z;
        p.in_x  = r.c_x;
        p.in_y  = r.c_y;
        p.in_z  = r.c_z;
      end else begin
        p = ring_point(r, ang);
      end
      p.index = k[5:0];
      p.last  = (k == segs);
      points_due.push_back(p);
      ang = ang + 16'(step);
    end
  endtask

  task automatic send_ring(input ring_t r, input logic on_center);
    in_tdata  <= r;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_ring(r, on_center);
  endtask

  // Sender pause: hold off until every point is out, then let the pipe empty
  task automatic settle();
    in_tvalid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SEG_COUNT:  seg_reg = val[SEG_W-1:0];
      REG_RADIUS_CUT: cut_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic row_t ring_row(input logic on_c, input int cx, cy, cz, ux, uy, uz,
                                    vx, vy, vz, rad, ang);
    row_t w;
    w                  = '0;
    w.kind             = ROW_RING;
    w.on_center        = on_c;
    w.ring.c_x         = cx;
    w.ring.c_y         = cy;
    w.ring.c_z         = cz;
    w.ring.u_x         = ux[15:0];
    w.ring.u_y         = uy[15:0];
    w.ring.u_z         = uz[15:0];
    w.ring.v_x         = vx[15:0];
    w.ring.v_y         = vy[15:0];
    w.ring.v_z         = vz[15:0];
    w.ring.radius      = rad;
    w.ring.start_angle = ang[15:0];
    return w;
  endfunction

  function automatic row_t cfg_row(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] val);
    row_t w;
    w         = '0;
    w.kind    = ROW_CFG;
    w.cfg_idx = idx;
    w.cfg_val = val;
    return w;
  endfunction

  function automatic int pick32();
    case ($urandom_range(0, 3))
      0:       return C_MAX;
      1:       return C_MIN;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic ring_t rand_ring();
    ring_t r;
    int    sel;
    sel = $urandom_range(0, 9);
    r   = IN_TDATA_W'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                       $urandom(), $urandom(), $urandom()});
    case (sel)
      0: ;                          // raw bits everywhere
      1: r.radius = '0;
      2: begin
        r.u_x = '0; r.u_y = '0; r.u_z = '0;
        r.v_x = '0; r.v_y = '0; r.v_z = '0;
      end
      3: begin
        r.c_x = pick32(); r.c_y = pick32(); r.c_z = pick32();
        r.u_x = pick16(); r.u_y = pick16(); r.u_z = pick16();
        r.v_x = pick16(); r.v_y = pick16(); r.v_z = pick16();
        r.radius = pick32();
      end
      default: begin
        // sensible geometry: no saturation of the outer vertex, so rounding is what gets exercised
        r.c_x    = int'($urandom_range(0, 33554431)) - 16777216;
        r.c_y    = int'($urandom_range(0, 33554431)) - 16777216;
        r.c_z    = int'($urandom_range(0, 33554431)) - 16777216;
        r.u_x    = 16'(int'($urandom_range(0, 32768)) - 16384);
        r.u_y    = 16'(int'($urandom_range(0, 32768)) - 16384);
        r.u_z    = 16'(int'($urandom_range(0, 32768)) - 16384);
        r.v_x    = 16'(int'($urandom_range(0, 32768)) - 16384);
        r.v_y    = 16'(int'($urandom_range(0, 32768)) - 16384);
        r.v_z    = 16'(int'($urandom_range(0, 32768)) - 16384);
        r.radius = int'($urandom_range(0, 8388607)) - 4194304;
      end
    endcase
    return r;
  endfunction

  // Result checker: every point against the oldest expectation
  always @(posedge clk) begin : point_check
    point_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata[197:0]};
      points_seen++;
      if (points_due.size() == 0) begin
        report_mismatch("point with none expected, index", 32'(got.index), '0);
      end else begin
        want = points_due.pop_front();
        if (got.out_x !== want.out_x) report_mismatch("outer_x", got.out_x, want.out_x);
        if (got.out_y !== want.out_y) report_mismatch("outer_y", got.out_y, want.out_y);
        if (got.out_z !== want.out_z) report_mismatch("outer_z", got.out_z, want.out_z);
        if (got.in_x !== want.in_x) report_mismatch("inner_x", got.in_x, want.in_x);
        if (got.in_y !== want.in_y) report_mismatch("inner_y", got.in_y, want.in_y);
        if (got.in_z !== want.in_z) report_mismatch("inner_z", got.in_z, want.in_z);
        if (got.index !== want.index)
          report_mismatch("point_index", 32'(got.index), 32'(want.index));
        if (got.last !== want.last)
          report_mismatch("last_point", 32'(got.last), 32'(want.last));
      end
    end
  end

  // Watchdog on handshake inactivity
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Output side: random stall patterns that change over the run; long holds now and then
  initial begin : sink
    int pct, pat_left, hold_at;
    pat_left = 0;
    pct      = 0;
    hold_at  = 600;
    out_tready <= 1'b0;
    forever begin
      if (points_seen >= hold_at) begin
        hold_at    = hold_at * 8;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        if (pat_left == 0) begin
          pat_left = $urandom_range(8, 96);
          case ($urandom_range(0, 3))
            0:       pct = 0;
            1:       pct = 20;
            2:       pct = 50;
            default: pct = 85;
          endcase
        end
        pat_left--;
        out_tready <= ($urandom_range(0, 99) >= pct);
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int  burst_left, gap;
    bit  gappy;
    logic [31:0] seg_val, cut_val;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_SEG_COUNT;
    cfg_data  <= '0;
    burst_left = 0;

    // Directed table; reset config is 16 segments, no cut
    plan.push_back(ring_row(0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 65536, 0));
    plan.push_back(ring_row(1, 123456, -654321, 7, 16384, 0, 0, 0, 16384, 0, 0, 16'h1234));
    plan.push_back(ring_row(1, C_MAX, C_MIN, 0, 0, 0, 0, 0, 0, 0, C_MAX, 16'hFFFF));
    plan.push_back(ring_row(0, C_MAX, C_MAX, C_MAX, 32767, 32767, 32767,
                            -32768, -32768, -32768, C_MAX, 16'hFFFF));
    plan.push_back(ring_row(0, C_MIN, C_MIN, C_MIN, -32768, -32768, -32768,
                            32767, 32767, 32767, C_MIN, 16'h0080));
    plan.push_back(ring_row(0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 1, 0));
    // angle wraps past a full turn
    plan.push_back(ring_row(0, -1, -1, -1, 16384, -16384, 8192, 8192, 16384, -16384,
                            -1, 16'hFF80));
    plan.push_back(cfg_row(REG_RADIUS_CUT, 32'h7FFF_FFFF));
    plan.push_back(ring_row(0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 32'h40000, 16'h4000));
    plan.push_back(ring_row(1, -5, 9, 77, 16384, 100, -3, 20, 16384, 5, 0, 16'h00C3));
    plan.push_back(cfg_row(REG_RADIUS_CUT, 32'h8000_0000));
    plan.push_back(ring_row(0, 0, C_MAX, C_MIN, 32767, -32768, 16384,
                            -32768, 32767, 0, C_MAX, 16'h2000));
    plan.push_back(ring_row(0, 1000, -1000, 0, 16384, 0, 0, 0, 0, 16384, C_MIN, 16'h0001));
    // segment counts below the minimum clamp to three
    plan.push_back(cfg_row(REG_SEG_COUNT, 32'd0));
    plan.push_back(ring_row(0, 65536, 0, -65536, 11585, 11585, 0, -11585, 11585, 0,
                            32'h18000, 0));
    plan.push_back(cfg_row(REG_SEG_COUNT, 32'd2));
    plan.push_back(ring_row(0, 0, 0, 0, 0, 16384, 0, 0, 0, 16384, 32'h00030000, 16'h8000));
    // upper data bits must be dropped: all ones gives 63 segments
    plan.push_back(cfg_row(REG_SEG_COUNT, 32'hFFFF_FFFF));
    plan.push_back(ring_row(0, 12, 34, 56, 16384, 0, 0, 0, 16384, 0, 32'h7FFF, 16'h0033));
    // unused indexes: nothing may change
    plan.push_back(cfg_row(REG_SPARE_2, 32'd0));
    plan.push_back(cfg_row(REG_SPARE_3, 32'hFFFF_FFFF));
    plan.push_back(ring_row(0, 0, 0, 0, -16384, 0, 0, 0, -16384, 0, 32'h00020000, 0));
    plan.push_back(cfg_row(REG_SEG_COUNT, 32'd3));
    plan.push_back(cfg_row(REG_RADIUS_CUT, 32'h0001_0000));
    plan.push_back(ring_row(0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0, 32'h00050000, 16'hFFFF));
    plan.push_back(cfg_row(REG_SEG_COUNT, 32'd17));
    plan.push_back(ring_row(0, -300000, 300000, 1, 9000, -9000, 4000, 100, 200, -16000,
                            32'h0001_8000, 16'h00FF));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].cfg_idx, plan[i].cfg_val);
      end else begin
        send_ring(plan[i].ring, plan[i].on_center);
      end
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph % 6)
        0:       seg_val = 32'd63;
        1:       seg_val = $urandom_range(0, 2);
        2:       seg_val = 32'd3;
        default: seg_val = $urandom_range(4, 63);
      endcase
      write_reg(REG_SEG_COUNT, ($urandom() & 32'hFFFF_FFC0) | seg_val);
      case ($urandom_range(0, 4))
        0:       cut_val = 32'd0;
        1:       cut_val = 32'h7FFF_FFFF;
        2:       cut_val = 32'h8000_0000;
        3:       cut_val = 32'(int'($urandom_range(0, 2097151)) - 1048576);
        default: cut_val = $urandom();
      endcase
      write_reg(REG_RADIUS_CUT, cut_val);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, $urandom());
      gappy = (ph % 3 != 1);
      for (int n = 0; n < RINGS_PER_PHASE; n++) begin
        send_ring(rand_ring(), 1'b0);
        if (gappy) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            gap        = $urandom_range(1, 40);
            in_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left--;
        end
      end
    end

    in_tvalid <= 1'b0;
    while (points_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
